[src/bsa_pkg.sv]
// Shared constants and types of the brick slot allocator.
`timescale 1ns / 1ps
`default_nettype none
package bsa_pkg;

	localparam int NUM_SLOTS    = 1024;
	localparam int BRICK_VOXELS = 512;
	localparam int SLOT_W       = $clog2(NUM_SLOTS);
	localparam int COUNT_W      = SLOT_W + 1;
	localparam int BRICK_SHIFT  = $clog2(BRICK_VOXELS);
	localparam int EB_W         = 5;
	localparam int OFFSET_W     = 23;
	localparam int PROD_W       = SLOT_W + EB_W + BRICK_SHIFT;

	localparam logic [EB_W-1:0]     EB_RESET   = EB_W'(4);
	localparam logic [OFFSET_W-1:0] OFFSET_MAX = {OFFSET_W{1'b1}};

	// request codes
	localparam logic [1:0] ACT_ALLOC = 2'd0;
	localparam logic [1:0] ACT_FREE  = 2'd1;
	localparam logic [1:0] ACT_GET   = 2'd2;

	// result codes
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_INVALID = 2'd1;
	localparam logic [1:0] ST_FULL    = 2'd2;

	// packed so that slot_out lands in the lowest bits
	typedef struct packed {
		logic [COUNT_W-1:0]  in_use_count;
		logic [1:0]          status;
		logic [OFFSET_W-1:0] byte_offset;
		logic [SLOT_W-1:0]   slot_out;
	} bsa_result_t;

	localparam int RES_W   = $bits(bsa_result_t);
	localparam int M_BYTES = (RES_W + 7) / 8;

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_EXEC = 2'b10
	} bsa_state_t;

endpackage
`default_nettype wire

[src/bsa_ram.sv]
// Generic single-port-write, single-port-read synchronous RAM with a registered read port.
`timescale 1ns / 1ps
`default_nettype none
module bsa_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 2
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// hold the last read word while no read is issued
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

[src/bsa_engine.sv]
// Request sequencer: reads occupancy and free queue, updates them and the counters.
`timescale 1ns / 1ps
`default_nettype none
module bsa_engine
	import bsa_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              req_valid,
	output logic                   req_ready,
	input  wire logic [1:0]        req_action,
	input  wire logic [SLOT_W-1:0] req_slot,
	input  wire logic [EB_W-1:0]   element_bytes,
	output logic                   res_valid,
	input  wire logic              res_ready,
	output bsa_result_t            res
);

	bsa_state_t state_q;

	logic [1:0]         act_q;
	logic [SLOT_W-1:0]  slot_q;
	logic [SLOT_W-1:0]  head_q;
	logic [SLOT_W-1:0]  tail_q;
	logic [COUNT_W-1:0] qcount_q;
	logic [COUNT_W-1:0] hw_q;
	logic [COUNT_W-1:0] total_q;

	logic              accept;
	logic              fire;
	logic              occ_rdata;
	logic [SLOT_W-1:0] q_rdata;

	logic              occ_we;
	logic [SLOT_W-1:0] occ_waddr;
	logic              occ_wdata;
	logic              q_we;

	logic               live;
	logic [PROD_W-1:0]  prod;
	logic [SLOT_W-1:0]  head_d;
	logic [SLOT_W-1:0]  tail_d;
	logic [COUNT_W-1:0] qcount_d;
	logic [COUNT_W-1:0] hw_d;
	logic [COUNT_W-1:0] total_d;

	assign req_ready = (state_q == S_IDLE);
	assign accept    = req_valid && req_ready;
	assign res_valid = (state_q == S_EXEC);
	assign fire      = res_valid && res_ready;

	// occupancy bits at or above the high-water mark were never written; the live check masks them
	bsa_ram #(.WIDTH(1), .DEPTH(NUM_SLOTS)) u_occ (
		.clk   (clk),
		.we    (occ_we),
		.waddr (occ_waddr),
		.wdata (occ_wdata),
		.re    (accept),
		.raddr (req_slot),
		.rdata (occ_rdata)
	);

	bsa_ram #(.WIDTH(SLOT_W), .DEPTH(NUM_SLOTS)) u_queue (
		.clk   (clk),
		.we    (q_we),
		.waddr (tail_q),
		.wdata (slot_q),
		.re    (accept),
		.raddr (head_q),
		.rdata (q_rdata)
	);

	assign live = ({1'b0, slot_q} < hw_q) && occ_rdata;
	assign prod = (PROD_W'(slot_q) * PROD_W'(element_bytes)) << BRICK_SHIFT;

	always_comb begin
		res.slot_out     = slot_q;
		res.byte_offset  = '0;
		res.status       = ST_OK;
		occ_we           = 1'b0;
		occ_waddr        = slot_q;
		occ_wdata        = 1'b0;
		q_we             = 1'b0;
		head_d           = head_q;
		tail_d           = tail_q;
		qcount_d         = qcount_q;
		hw_d             = hw_q;
		total_d          = total_q;
		case (act_q)
			ACT_ALLOC: begin
				if (qcount_q != '0) begin
					res.slot_out = q_rdata;
					head_d       = (head_q == SLOT_W'(NUM_SLOTS - 1)) ? '0 : head_q + 1'b1;
					qcount_d     = qcount_q - 1'b1;
					occ_we       = 1'b1;
					total_d      = total_q + 1'b1;
				end else if (hw_q != COUNT_W'(NUM_SLOTS)) begin
					res.slot_out = hw_q[SLOT_W-1:0];
					hw_d         = hw_q + 1'b1;
					occ_we       = 1'b1;
					total_d      = total_q + 1'b1;
				end else begin
					res.slot_out = '0;
					res.status   = ST_FULL;
				end
				occ_waddr = res.slot_out;
				occ_wdata = 1'b1;
			end
			ACT_FREE: begin
				if (live) begin
					occ_we   = 1'b1;
					q_we     = 1'b1;
					tail_d   = (tail_q == SLOT_W'(NUM_SLOTS - 1)) ? '0 : tail_q + 1'b1;
					qcount_d = qcount_q + 1'b1;
					total_d  = total_q - 1'b1;
				end else begin
					res.status = ST_INVALID;
				end
			end
			ACT_GET: begin
				if (live) begin
					res.byte_offset = (prod > PROD_W'(OFFSET_MAX)) ? OFFSET_MAX
					                                                : prod[OFFSET_W-1:0];
				end else begin
					res.status = ST_INVALID;
				end
			end
			default: begin
				res.status = ST_INVALID;
			end
		endcase
		res.in_use_count = total_d;
		occ_we           = occ_we && fire;
		q_we             = q_we && fire;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			head_q   <= '0;
			tail_q   <= '0;
			qcount_q <= '0;
			hw_q     <= '0;
			total_q  <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (fire) begin
						state_q  <= S_IDLE;
						head_q   <= head_d;
						tail_q   <= tail_d;
						qcount_q <= qcount_d;
						hw_q     <= hw_d;
						total_q  <= total_d;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			act_q  <= req_action;
			slot_q <= req_slot;
		end
	end

endmodule
`default_nettype wire

[src/brick_slot_allocator_top.sv]
// Top level of the brick slot allocator: stream ports, configuration register, output register.
`timescale 1ns / 1ps
`default_nettype none
// Usage
//   s_* carries one request word: allocate a slot, free a slot, or ask for a
//   slot's byte offset. m_* returns exactly one result word per request, in order.
//   cfg_* writes element_bytes (bytes per voxel element); cfg_ready is always
//   high, and a write belongs in a quiet spell with no request in flight.
// Timing
//   A request is taken when s_tvalid and s_tready are both high, and the
//   occupancy bit and the head of the free queue are read from their RAMs at
//   that edge. The result is then formed from them; it is written back into the
//   RAMs and counters, and loaded into the output register that drives m_tvalid,
//   only once that register can take it. Only one request is in flight, and it
//   holds the input until written back.
// Reset
//   arst_n clears the counters, the queue pointers and the output valid flag, and
//   element_bytes returns to 4. The occupancy RAM needs no clearing pass: slots
//   at or above the high-water mark read as free, and no slot is allocated
//   below it without its bit being written.
// Back-pressure
//   While m_tready is low the result word holds in the output register; the
//   engine may still take one more request and hold its result until the
//   register frees, and s_tready stays low from then on until that happens.
module brick_slot_allocator_top
	import bsa_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 s_tvalid,
	output logic                      s_tready,
	input  wire logic [15:0]          s_tdata,   // [1:0] action, [11:2] slot_index
	output logic                      m_tvalid,
	input  wire logic                 m_tready,
	output logic [M_BYTES*8-1:0]      m_tdata,   // [9:0] slot_out, [32:10] byte_offset,
	                                             // [34:33] status, [45:35] in_use_count
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [EB_W-1:0]      cfg_data
);

	logic [EB_W-1:0] element_bytes_q;
	logic            out_valid_q;
	bsa_result_t     out_q;

	logic        res_valid;
	logic        res_ready;
	bsa_result_t res;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			element_bytes_q <= EB_RESET;
		end else if (cfg_valid && cfg_ready) begin
			element_bytes_q <= cfg_data;
		end
	end

	bsa_engine u_engine (
		.clk           (clk),
		.arst_n        (arst_n),
		.req_valid     (s_tvalid),
		.req_ready     (s_tready),
		.req_action    (s_tdata[1:0]),
		.req_slot      (s_tdata[SLOT_W+1:2]),
		.element_bytes (element_bytes_q),
		.res_valid     (res_valid),
		.res_ready     (res_ready),
		.res           (res)
	);

	// take a new result when the register is empty or drains this cycle
	assign res_ready = !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(M_BYTES*8-RES_W){1'b0}}, out_q};

	// a taken request closes the input until the output register takes its result
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("request accepted while another is in flight");

	// the allocated count never passes the capacity
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (res.in_use_count <= COUNT_W'(NUM_SLOTS)))
		else $error("in-use count beyond capacity");

	// a full report grants nothing and gives no offset
	a_full_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res.status == ST_FULL) |-> (res.slot_out == '0 && res.byte_offset == '0))
		else $error("full result carries a slot or offset");

	// an offset only comes with a successful get
	a_offset_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res.byte_offset != '0) |-> (res.status == ST_OK))
		else $error("offset on a failed request");

endmodule
`default_nettype wire
